[hw/rtl/sem_pkg.sv]
// Shared types, constants and the Sobel magnitude helpers.
`default_nettype none
package sem_pkg;
  localparam int MaxWidthDef = 1024;
  localparam int MaxHeight = 4096;
  localparam logic [10:0] WidthReset = 11'd640;
  localparam logic [12:0] HeightReset = 13'd480;
  localparam logic [0:0] RegWidth = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef logic [23:0] pix_t;

  // Window shift for emission: rows up (pad bottom), columns left (pad right).
  typedef enum logic [1:0] {
    SHIFT_NONE = 2'd0,
    SHIFT_COL  = 2'd1,
    SHIFT_ROW  = 2'd2,
    SHIFT_BOTH = 2'd3
  } shift_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic   load;
    logic   emit;
    shift_t shift;
    logic   last;
    logic   flast;
  } sem_cmd_t;

  // Datapath status to controller.
  typedef struct packed {
    logic busy;
  } sem_stat_t;

  // Squared gradient sum of one channel, clamped to 17 bits; every value at
  // or above the top threshold already gives the saturated magnitude.
  function automatic logic [16:0] sq_sum(input logic signed [10:0] gx,
                                         input logic signed [10:0] gy);
    logic signed [21:0] px;
    logic signed [21:0] py;
    logic [21:0] s;
    begin
      px = gx * gx;
      py = gy * gy;
      s = $unsigned(px) + $unsigned(py);
      sq_sum = (s > 22'h1FFFF) ? 17'h1FFFF : s[16:0];
    end
  endfunction
endpackage
`default_nettype wire

[hw/rtl/sem_stream_if.sv]
// Valid/ready stream interface carrying one payload.
`default_nettype none
interface sem_stream_if #(parameter int W = 24);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/sobel_edge_magnitude.sv]
// Top level: Sobel edge magnitude over an RGB raster stream.
//  channel | dir | payload
//  pix_in  | in  | in_red, in_green, in_blue
//  pix_out | out | out_red, out_green, out_blue, run_last, frame_last
//  apb     | in  | image_width @0x0, image_height @0x4
// An item enters through the line buffer read and the window shift, then each
// result goes around the 8-step magnitude search, one at a time.
// rst is synchronous; a stalled output holds the search sequencer; no new item until
// all results of the previous one are registered.
`default_nettype none
module sobel_edge_magnitude import sem_pkg::*; #(
  parameter int MaxWidth = MaxWidthDef
) (
  input  wire logic clk,
  input  wire logic rst,
  sem_stream_if.sink pix_in,
  sem_stream_if.source pix_out,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [10:0] image_width;
  logic [12:0] image_height;
  logic wr, restart;
  sem_cmd_t cmd;
  sem_stat_t stat;
  logic [$clog2(MaxWidth)-1:0] col;
  logic ge1, ge2, cz;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign restart = wr && (paddr[2] == RegWidth || paddr[2] == RegHeight);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WidthReset;
      image_height <= HeightReset;
    end else if (wr) begin
      if (paddr[2] == RegWidth) image_width <= pwdata[10:0];
      else image_height <= pwdata[12:0];
    end
  end
  assign prdata = (paddr[2] == RegWidth) ? {21'd0, image_width} : {19'd0, image_height};

  sem_ctrl #(.MaxWidth(MaxWidth)) u_ctrl (
    .clk, .rst, .image_width, .image_height, .restart,
    .in_valid(pix_in.valid), .in_ready(pix_in.ready), .stat, .cmd,
    .col, .row_ge1(ge1), .row_ge2(ge2), .col_zero(cz)
  );

  sem_datapath #(.MaxWidth(MaxWidth)) u_dp (
    .clk, .rst, .cmd, .col, .row_ge1(ge1), .row_ge2(ge2), .col_zero(cz),
    .in_px(pix_in.data), .stat, .out_valid(pix_out.valid),
    .out_ready(pix_out.ready), .out_data(pix_out.data)
  );
endmodule
`default_nettype wire

[hw/rtl/sem_datapath.sv]
// Line buffers, window, gradients, magnitude search and output register.
`default_nettype none
module sem_datapath import sem_pkg::*; #(
  parameter int MaxWidth = MaxWidthDef
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire sem_cmd_t cmd,
  input  wire logic [$clog2(MaxWidth)-1:0] col,
  input  wire logic row_ge1,
  input  wire logic row_ge2,
  input  wire logic col_zero,
  input  wire pix_t in_px,
  output sem_stat_t stat,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [25:0] out_data
);
  localparam int AW = $clog2(MaxWidth);

  pix_t line_above [MaxWidth];
  pix_t line_current [MaxWidth];
  pix_t top_q, mid_q, px_q;
  logic ge1_q, ge2_q, clr_q, push_q;
  pix_t win [9];
  logic [AW-1:0] col_q;

  // Stage 1: read line buffers, write back shifted rows.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      top_q <= line_above[col];
      mid_q <= line_current[col];
      line_current[col] <= in_px;
      px_q <= in_px;
      ge1_q <= row_ge1;
      ge2_q <= row_ge2;
      clr_q <= col_zero;
      col_q <= col;
    end
  end
  always_ff @(posedge clk) begin
    if (push_q) line_above[col_q] <= mid_q;
  end
  always_ff @(posedge clk) begin
    if (rst) push_q <= 1'b0;
    else push_q <= cmd.load;
  end

  // Stage 2: shift window.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) win[k] <= '0;
    end else if (push_q) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]   <= clr_q ? '0 : win[r*3+1];
        win[r*3+1] <= clr_q ? '0 : win[r*3+2];
      end
      win[2] <= ge2_q ? top_q : '0;
      win[5] <= ge1_q ? mid_q : '0;
      win[8] <= px_q;
    end
  end

  // Emission window with shift.
  pix_t ew [9];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r + (cmd.shift[1] ? 1 : 0) < 3) && (c + (cmd.shift[0] ? 1 : 0) < 3))
          ew[r*3+c] = win[(r + (cmd.shift[1] ? 1 : 0))*3 + c + (cmd.shift[0] ? 1 : 0)];
        else
          ew[r*3+c] = '0;
      end
    end
  end

  // Gradients and squared sums, registered.
  logic [16:0] g_q [3];
  logic [16:0] g_d [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic signed [10:0] gx, gy;
      gx = 11'(ew[2][ch*8+:8]) - 11'(ew[0][ch*8+:8])
         + 11'({ew[5][ch*8+:8], 1'b0}) - 11'({ew[3][ch*8+:8], 1'b0})
         + 11'(ew[8][ch*8+:8]) - 11'(ew[6][ch*8+:8]);
      gy = 11'(ew[6][ch*8+:8]) - 11'(ew[0][ch*8+:8])
         + 11'({ew[7][ch*8+:8], 1'b0}) - 11'({ew[1][ch*8+:8], 1'b0})
         + 11'(ew[8][ch*8+:8]) - 11'(ew[2][ch*8+:8]);
      g_d[ch] = sq_sum(gx, gy);
    end
  end

  // Magnitude by bitwise search: 8 steps over the sequencer, one per cycle.
  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_RUN  = 3'b010,
    M_OUT  = 3'b100
  } mstate_t;
  mstate_t ms;
  logic [2:0] bit_i;
  logic [7:0] n_q [3];
  logic last_q, flast_q;

  // Test candidate: n>=k iff g >= k*k-k+1.
  logic [7:0] cand [3];
  logic [15:0] kk [3];
  logic ok [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      cand[ch] = n_q[ch] | (8'd1 << bit_i);
      kk[ch] = cand[ch] * cand[ch];
      ok[ch] = {1'b0, g_q[ch]} >= ({2'b0, kk[ch]} - {10'b0, cand[ch]} + 18'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms <= M_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Load a finished item into the output register, or drop a taken one.
      if (ms == M_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (ms)
        M_IDLE: begin
          if (cmd.emit) begin
            for (int ch = 0; ch < 3; ch++) begin
              g_q[ch] <= g_d[ch];
              n_q[ch] <= '0;
            end
            last_q <= cmd.last;
            flast_q <= cmd.flast;
            bit_i <= 3'd7;
            ms <= M_RUN;
          end
        end
        M_RUN: begin
          for (int ch = 0; ch < 3; ch++) if (ok[ch]) n_q[ch] <= cand[ch];
          bit_i <= bit_i - 3'd1;
          if (bit_i == 3'd0) ms <= M_OUT;
        end
        M_OUT: begin
          if (!out_valid || out_ready) begin
            out_data <= {n_q[2], n_q[1], n_q[0], last_q, flast_q};
            ms <= M_IDLE;
          end
        end
        default: ms <= M_IDLE;
      endcase
    end
  end

  assign stat.busy = (ms != M_IDLE) || push_q;
endmodule
`default_nettype wire

[hw/rtl/sem_ctrl.sv]
// Controller: frame position, emission sequencing and configuration.
`default_nettype none
module sem_ctrl import sem_pkg::*; #(
  parameter int MaxWidth = MaxWidthDef
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [10:0] image_width,
  input  wire logic [12:0] image_height,
  input  wire logic restart,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire sem_stat_t stat,
  output sem_cmd_t cmd,
  output logic [$clog2(MaxWidth)-1:0] col,
  output logic row_ge1,
  output logic row_ge2,
  output logic col_zero
);
  localparam int AW = $clog2(MaxWidth);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WAIT = 4'b0010,
    S_EMIT = 4'b0100,
    S_BUSY = 4'b1000
  } state_t;
  state_t state;

  logic [AW-1:0] wm1;
  logic [11:0] hm1;
  logic [AW-1:0] col_r;
  logic [11:0] row_r;
  logic [3:0] pend;
  logic [1:0] wcnt;

  // Effective limits minus one.
  always_comb begin
    if (image_width == 11'd0) wm1 = '0;
    else if (32'(image_width) > MaxWidth) wm1 = AW'(MaxWidth - 1);
    else wm1 = AW'(image_width - 11'd1);
    if (image_height == 13'd0) hm1 = '0;
    else if (image_height > 13'(MaxHeight)) hm1 = 12'(MaxHeight - 1);
    else hm1 = 12'(image_height - 13'd1);
  end

  assign col = col_r;
  assign row_ge1 = row_r != 12'd0;
  assign row_ge2 = row_r > 12'd1;
  assign col_zero = col_r == '0;
  assign in_ready = state == S_IDLE;

  // Next emission in order.
  logic [1:0] sel;
  logic [3:0] rest;
  always_comb begin
    sel = 2'd0;
    if (pend[0]) sel = 2'd0;
    else if (pend[1]) sel = 2'd1;
    else if (pend[2]) sel = 2'd2;
    else sel = 2'd3;
    rest = pend & ~(4'd1 << sel);
    cmd.load = in_valid && in_ready;
    cmd.emit = (state == S_EMIT) && !stat.busy;
    case (sel)
      2'd0: cmd.shift = SHIFT_NONE;
      2'd1: cmd.shift = SHIFT_COL;
      2'd2: cmd.shift = SHIFT_ROW;
      default: cmd.shift = SHIFT_BOTH;
    endcase
    cmd.last = rest == 4'd0;
    cmd.flast = sel == 2'd3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      col_r <= '0;
      row_r <= '0;
      pend <= '0;
      wcnt <= '0;
    end else if (restart) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load) begin
            pend <= {row_r == hm1 && col_r == wm1, row_r == hm1 && col_r != '0,
                     row_r != 12'd0 && col_r == wm1, row_r != 12'd0 && col_r != '0};
            if (col_r == wm1) begin
              col_r <= '0;
              row_r <= (row_r == hm1) ? 12'd0 : row_r + 12'd1;
            end else begin
              col_r <= col_r + AW'(1);
            end
            wcnt <= 2'd2;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          wcnt <= wcnt - 2'd1;
          if (wcnt == 2'd1) state <= (pend == 4'd0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          if (cmd.emit) begin
            pend <= rest;
            state <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (!stat.busy && !cmd.emit) state <= (pend == 4'd0) ? S_IDLE : S_EMIT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[dv/sobel_edge_magnitude_checker.sv]
// Checker: tracks register writes, predicts Sobel magnitudes and compares output items.
module sobel_edge_magnitude_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [23:0] in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [25:0] out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          results_seen
);
  import sem_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       run_last;
    logic       frame_last;
  } edge_px_t;

  localparam int LineLen = 1024;

  logic [10:0] width_reg;
  logic [12:0] height_reg;
  pix_t        row_two_back [LineLen];
  pix_t        row_one_back [LineLen];
  pix_t        win [9];
  int          col_pos;
  int          row_pos;
  edge_px_t    expected_q [$];

  // Rounded square root, saturated at 255, by threshold count.
  function automatic logic [7:0] root_sat(int g);
    int n;
    n = 0;
    while (n < 255 && g >= n * n + n + 1) n++;
    return n[7:0];
  endfunction

  function automatic logic [7:0] chan_mag(pix_t w [9], int sh);
    int gx;
    int gy;
    int r;
    int wt;
    gx = 0;
    gy = 0;
    for (r = 0; r < 3; r++) begin
      wt = (r == 1) ? 2 : 1;
      gx += wt * (int'(w[r*3+2][sh+:8]) - int'(w[r*3][sh+:8]));
      gy += wt * (int'(w[6+r][sh+:8]) - int'(w[r][sh+:8]));
    end
    return root_sat(gx * gx + gy * gy);
  endfunction

  // Build one expected item from the window, shifted up by dr rows and left by dc columns.
  function automatic edge_px_t window_result(int dr, int dc, logic fl);
    pix_t     w [9];
    edge_px_t e;
    int       r;
    int       c;
    for (r = 0; r < 3; r++)
      for (c = 0; c < 3; c++)
        w[r*3+c] = (r + dr < 3 && c + dc < 3) ? win[(r+dr)*3 + c + dc] : '0;
    e.red = chan_mag(w, 16);
    e.green = chan_mag(w, 8);
    e.blue = chan_mag(w, 0);
    e.run_last = 1'b0;
    e.frame_last = fl;
    return e;
  endfunction

  task automatic predict_pixel(pix_t px);
    int       wd;
    int       ht;
    int       i;
    int       j;
    int       r;
    logic     lastcol;
    logic     lastrow;
    edge_px_t res [$];
    pix_t     top;
    pix_t     mid;
    wd = (width_reg == 0) ? 1 : (width_reg > LineLen) ? LineLen : int'(width_reg);
    ht = (height_reg == 0) ? 1 : (height_reg > MaxHeight) ? MaxHeight : int'(height_reg);
    i = (row_pos >= ht) ? ht - 1 : row_pos;
    j = (col_pos >= wd) ? wd - 1 : col_pos;
    lastcol = (j == wd - 1);
    lastrow = (i == ht - 1);
    top = (i >= 2) ? row_two_back[j] : '0;
    mid = (i >= 1) ? row_one_back[j] : '0;
    row_two_back[j] = row_one_back[j];
    row_one_back[j] = px;
    if (j == 0) foreach (win[k]) win[k] = '0;
    for (r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    if (i >= 1 && j >= 1) res.push_back(window_result(0, 0, 1'b0));
    if (i >= 1 && lastcol) res.push_back(window_result(0, 1, 1'b0));
    if (lastrow && j >= 1) res.push_back(window_result(1, 0, 1'b0));
    if (lastrow && lastcol) res.push_back(window_result(1, 1, 1'b1));
    if (res.size() > 0) res[res.size()-1].run_last = 1'b1;
    foreach (res[k]) expected_q.push_back(res[k]);
    // Advance the raster position.
    j++;
    if (j >= wd) begin
      j = 0;
      i++;
      if (i >= ht) i = 0;
    end
    col_pos = j;
    row_pos = i;
  endtask

  always @(posedge clk) begin
    edge_px_t got;
    edge_px_t want;
    if (rst) begin
      width_reg <= WidthReset;
      height_reg <= HeightReset;
      foreach (win[k]) win[k] = '0;
      col_pos = 0;
      row_pos = 0;
      expected_q.delete();
      errors <= 0;
      results_seen <= 0;
    end else begin
      // Register writes restart the frame position.
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegHeight) height_reg <= pwdata[12:0];
        else width_reg <= pwdata[10:0];
        col_pos = 0;
        row_pos = 0;
      end
      if (in_valid && in_ready) predict_pixel(in_data);
      if (out_valid && out_ready) begin
        got = out_data;
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("ERROR: unexpected output item %h", got);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display("ERROR: item %0d exp %0d/%0d/%0d rl=%b fl=%b got %0d/%0d/%0d rl=%b fl=%b",
                       results_seen, want.red, want.green, want.blue, want.run_last,
                       want.frame_last, got.red, got.green, got.blue, got.run_last,
                       got.frame_last);
            errors <= errors + 1;
          end
        end
      end
    end
    // Publish the count of results still owed.
    pending <= expected_q.size();
  end
endmodule

[dv/sobel_edge_magnitude_test.sv]
// Testbench top: clock, reset, pixel stimulus, register writes and the verdict.
module sobel_edge_magnitude_test;
  import sem_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          results_seen;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_left;
  int          pixels_sent;
  int          frames_sent;

  sem_stream_if #(.W(24)) pix_in ();
  sem_stream_if #(.W(26)) pix_out ();

  sobel_edge_magnitude u_top (
    .clk(clk), .rst(rst), .pix_in(pix_in.sink), .pix_out(pix_out.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sobel_edge_magnitude_checker u_chk (
    .clk(clk), .rst(rst),
    .in_valid(pix_in.valid), .in_ready(pix_in.ready), .in_data(pix_in.data),
    .out_valid(pix_out.valid), .out_ready(pix_out.ready), .out_data(pix_out.data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Drive the receiver: random stalls, or a long hold when one is pending.
  initial pix_out.ready = 1'b0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      pix_out.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Give up after a generous time.
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Let all results drain, plus margin for items that make none.
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_frame(int w, int h);
    drain();
    reg_write({RegWidth, 2'b00}, w);
    reg_write({RegHeight, 2'b00}, h);
  endtask

  // Offer one item, with random idle gaps ahead of it; return at the next falling edge.
  task automatic send_pixel(logic [23:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(negedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.data <= px;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    @(negedge clk);
    pixels_sent++;
  endtask

  task automatic stop_sending();
    pix_in.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_frame(int w, int h, int mode);
    logic [23:0] px;
    int n;
    set_frame(w, h);
    for (n = 0; n < w * h; n++) begin
      case (mode)
        0: px = 24'($urandom);
        1: px = ((n + n / w) % 2) ? 24'hFFFFFF : 24'h000000;
        default: px = $urandom_range(1) ? 24'hFFFFFF : {8'($urandom_range(255)), 16'h0};
      endcase
      send_pixel(px);
    end
    stop_sending();
    frames_sent++;
  endtask

  initial begin
    int w;
    int h;
    int k;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix_in.valid = 1'b0;
    pix_in.data = '0;
    hold_left = 0;
    pixels_sent = 0;
    frames_sent = 0;
    send_idle_pct = 10;
    recv_idle_pct = 52;
    rst = 1'b1;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: single pixel, zero-sized registers, saturating patterns, small frames.
    send_frame(1, 1, 2);
    send_frame(0, 0, 0);
    send_frame(3, 3, 1);
    send_frame(2, 2, 1);
    send_frame(1, 3, 0);
    // Oversized and extreme registers: a few pixels of row 0, then restart.
    set_frame(2047, 8191);
    for (k = 0; k < 3; k++) send_pixel(k[0] ? 24'hFFFFFF : 24'h000000);
    stop_sending();
    set_frame(1024, 4096);
    for (k = 0; k < 2; k++) send_pixel(24'($urandom));
    stop_sending();

    // Random frames, mostly small, across the idling phases.
    while (pixels_sent < 440) begin
      if (pixels_sent > 330) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (pixels_sent > 180) begin
        send_idle_pct = 52;
        recv_idle_pct = 10;
      end
      if (frames_sent == 12) begin
        // Hold the receiver off so the block backs up, then wait for a full drain.
        set_frame(8, 4);
        hold_left = 400;
        for (k = 0; k < 32; k++) send_pixel(24'($urandom));
        stop_sending();
        while (pending != 0) @(negedge clk);
        frames_sent++;
      end else if (frames_sent == 20) begin
        send_frame(40, 3, 0);
      end else if ($urandom_range(9) == 0) begin
        // Broken frame: cut short by a new setting.
        set_frame($urandom_range(12, 3), $urandom_range(6, 2));
        for (k = $urandom_range(5, 1); k > 0; k--) send_pixel(24'($urandom));
        stop_sending();
        frames_sent++;
      end else begin
        w = $urandom_range(10, 1);
        h = $urandom_range(6, 1);
        send_frame(w, h, $urandom_range(9) == 0 ? 2 : 0);
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("Sent %0d pixels in %0d frames, checked %0d output items.",
             pixels_sent, frames_sent, results_seen);
    $display("Covered zero, oversized and extreme register values and back-pressure.");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

[sim.f]
hw/rtl/sem_pkg.sv
hw/rtl/sem_stream_if.sv
hw/rtl/sem_datapath.sv
hw/rtl/sem_ctrl.sv
hw/rtl/sobel_edge_magnitude.sv
dv/sobel_edge_magnitude_checker.sv
dv/sobel_edge_magnitude_test.sv
